@@ rtl/core/dfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfd_pkg: shared types and constants of the decimal fraction divider
// Sequencer states, the control word from sequencer to datapath and the
// fixed widths of the result fields.
// ----------------------------------------------------------------------------
package dfd_pkg;

	localparam int QUOT_W      = 32;  // quotient field width
	localparam int FRAC_W      = 31;  // packed fraction field width
	localparam int COUNT_W     = 4;   // digit count field width
	localparam int DIGIT_STEPS = 4;   // restoring steps per decimal digit
	localparam int STEP_W      = 2;   // index of a step within a digit
	localparam int RADIX_GUARD = 4;   // extra bits for remainder times ten

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_DIGIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              load;
		logic              div_step;
		logic              mul_step;
		logic              dig_step;
		logic              dig_last;
		logic [STEP_W-1:0] shift;
	} ctrl_t;

endpackage

@@ rtl/core/dfd_sub_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfd_sub_unit: shared trial subtractor
// Forms a - b and flags whether it went without borrow; used for every
// quotient bit and every decimal digit step.
// ----------------------------------------------------------------------------
module dfd_sub_unit #(
	parameter int WIDTH = 36
) (
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	output logic [WIDTH-1:0] diff,
	output logic             ge
);

	logic [WIDTH:0] wide;

	assign wide = {1'b0, a} - {1'b0, b};
	assign diff = wide[WIDTH-1:0];
	assign ge   = ~wide[WIDTH];

endmodule

@@ rtl/core/dfd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfd_ctrl: division sequencer
// Steps the shared subtractor through the binary quotient bits, then
// through four restoring steps for each decimal fraction digit.
// ----------------------------------------------------------------------------
module dfd_ctrl #(
	parameter int DATA_WIDTH = 32,
	parameter int MAX_DIGITS = 9
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        divisor_zero,
	input  logic [dfd_pkg::COUNT_W-1:0] digit_count,
	input  logic                        out_ready,
	output logic                        in_ready,
	output logic                        out_valid,
	output dfd_pkg::ctrl_t              ctrl
);

	import dfd_pkg::*;

	localparam int CNT_W = $clog2(DATA_WIDTH);

	state_t              state_q;
	state_t              state_d;
	logic [CNT_W-1:0]    cnt_q;
	logic [STEP_W-1:0]   step_q;
	logic [COUNT_W-1:0]  digits_q;
	logic [COUNT_W-1:0]  digits_init;

	// zero digits acts as one, too many saturates
	always_comb begin
		if (digit_count == '0) begin
			digits_init = COUNT_W'(1);
		end else if (digit_count > COUNT_W'(MAX_DIGITS)) begin
			digits_init = COUNT_W'(MAX_DIGITS);
		end else begin
			digits_init = digit_count;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = divisor_zero ? ST_DONE : ST_DIV;
				end
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_DIGIT;
			end
			ST_DIGIT: begin
				if (step_q == '0) begin
					state_d = (digits_q == COUNT_W'(1)) ? ST_DONE : ST_MUL;
				end
			end
			ST_DONE: begin
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		out_valid     = (state_q == ST_DONE);
		ctrl.load     = in_valid && (state_q == ST_IDLE);
		ctrl.div_step = (state_q == ST_DIV);
		ctrl.mul_step = (state_q == ST_MUL);
		ctrl.dig_step = (state_q == ST_DIGIT);
		ctrl.dig_last = (state_q == ST_DIGIT) && (step_q == '0);
		ctrl.shift    = step_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			step_q   <= '0;
			digits_q <= '0;
		end else begin
			state_q <= state_d;
			if (ctrl.load) begin
				cnt_q    <= CNT_W'(DATA_WIDTH - 1);
				digits_q <= digits_init;
			end
			if (ctrl.div_step) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (ctrl.mul_step) begin
				step_q <= STEP_W'(DIGIT_STEPS - 1);
			end
			if (ctrl.dig_step) begin
				step_q <= step_q - STEP_W'(1);
				// advance to the next digit after its last step
				if (step_q == '0) begin
					digits_q <= digits_q - COUNT_W'(1);
				end
			end
		end
	end

endmodule

@@ rtl/core/decimal_fraction_divider.sv @@
`timescale 1ns / 1ps
// Sequence: the quotient bits are stepped first, then each fraction digit; a
// zero divisor goes straight from idle to done, skipping both.
// Handshake: a new word is taken only in idle, after the last result was accepted;
// the single shared subtractor takes one quotient bit or one digit step per cycle.
// Reset: arst_n clears the sequencer to idle; no word is held afterwards.
// ----------------------------------------------------------------------------
// decimal_fraction_divider: long division with decimal fraction digits
// Restoring binary division for the quotient, then remainder-times-ten
// steps giving one decimal digit per multiply step and four restoring steps, packed behind a 1.
// ----------------------------------------------------------------------------
module decimal_fraction_divider #(
	parameter int DATA_WIDTH = 32,
	parameter int MAX_DIGITS = 9
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [DATA_WIDTH-1:0]       dividend,
	input  logic [DATA_WIDTH-1:0]       divisor,
	input  logic [dfd_pkg::COUNT_W-1:0] digit_count,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [dfd_pkg::QUOT_W-1:0]  quotient,
	output logic [dfd_pkg::FRAC_W-1:0]  fraction_digits,
	output logic                        divide_by_zero
);

	import dfd_pkg::*;

	localparam int RW = DATA_WIDTH + RADIX_GUARD;

	ctrl_t                   ctrl;
	logic                    divisor_zero;
	logic [DATA_WIDTH-1:0]   dvs_q;
	logic [DATA_WIDTH-1:0]   quo_q;
	logic [RW-1:0]           rem_q;
	logic [STEP_W:0]         dig_q;
	logic [FRAC_W-1:0]       frac_q;
	logic                    dbz_q;
	logic [RW-1:0]           sub_a;
	logic [RW-1:0]           sub_b;
	logic [RW-1:0]           sub_diff;
	logic                    sub_ge;
	logic [RW-1:0]           partial;
	logic [RW-1:0]           rem_x10;
	logic [DIGIT_STEPS-1:0]  digit;
	logic [FRAC_W+3:0]       frac_wide;
	logic [FRAC_W+3:0]       frac_x10;
	logic [QUOT_W+DATA_WIDTH-1:0] quo_ext;

	assign divisor_zero = (divisor == '0);

	dfd_ctrl #(
		.DATA_WIDTH (DATA_WIDTH),
		.MAX_DIGITS (MAX_DIGITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.divisor_zero (divisor_zero),
		.digit_count  (digit_count),
		.out_ready    (out_ready),
		.in_ready     (in_ready),
		.out_valid    (out_valid),
		.ctrl         (ctrl)
	);

	// shift the next dividend bit into the partial remainder
	assign partial = {{(RADIX_GUARD - 1){1'b0}}, rem_q[DATA_WIDTH-1:0], quo_q[DATA_WIDTH-1]};
	assign rem_x10 = (rem_q << 3) + (rem_q << 1);

	always_comb begin
		if (ctrl.div_step) begin
			sub_a = partial;
			sub_b = {{RADIX_GUARD{1'b0}}, dvs_q};
		end else begin
			sub_a = rem_q;
			sub_b = {{RADIX_GUARD{1'b0}}, dvs_q} << ctrl.shift;
		end
	end

	dfd_sub_unit #(
		.WIDTH (RW)
	) u_sub (
		.a    (sub_a),
		.b    (sub_b),
		.diff (sub_diff),
		.ge   (sub_ge)
	);

	assign digit     = {dig_q, sub_ge};
	assign frac_wide = {4'b0000, frac_q};
	assign frac_x10  = (frac_wide << 3) + (frac_wide << 1) + {{FRAC_W{1'b0}}, digit};

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			dvs_q  <= divisor;
			rem_q  <= '0;
			dig_q  <= '0;
			dbz_q  <= divisor_zero;
			quo_q  <= divisor_zero ? '0 : dividend;
			frac_q <= divisor_zero ? '0 : FRAC_W'(1);
		end
		if (ctrl.div_step) begin
			rem_q <= sub_ge ? sub_diff : partial;
			quo_q <= {quo_q[DATA_WIDTH-2:0], sub_ge};
		end
		if (ctrl.mul_step) begin
			rem_q <= rem_x10;
			dig_q <= '0;
		end
		if (ctrl.dig_step) begin
			if (sub_ge) begin
				rem_q <= sub_diff;
			end
			dig_q <= digit[STEP_W:0];
			if (ctrl.dig_last) begin
				frac_q <= frac_x10[FRAC_W-1:0];
			end
		end
	end

	assign quo_ext         = {{QUOT_W{1'b0}}, quo_q};
	assign quotient        = quo_ext[QUOT_W-1:0];
	assign fraction_digits = frac_q;
	assign divide_by_zero  = dbz_q;

`ifndef SYNTH
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output sides open together");

	a_zero_div_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && divisor == '0) |=> (out_valid && divide_by_zero))
		else $error("zero divisor did not finish at once");

	a_zero_results: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && divide_by_zero) |-> (quotient == '0 && fraction_digits == '0))
		else $error("zero divisor gave non-zero results");

	a_leading_one: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !divide_by_zero) |-> (fraction_digits >= FRAC_W'(10)))
		else $error("fraction lost its leading one");
`endif

endmodule
